// ===== hw/rtl/iclfu_pkg.sv =====
// ----------------------------------------------------------------------------
// iclfu_pkg
// Shared types and constants of the inode slot cache with LFU replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package iclfu_pkg;

    // fixed payload field widths
    localparam int INODE_W = 16;
    localparam int SLOT_W  = 4;

    // command codes
    localparam logic CMD_LOOKUP     = 1'b0;
    localparam logic CMD_MARK_DIRTY = 1'b1;

    // request item
    typedef struct packed {
        logic               cmd;
        logic [INODE_W-1:0] inode_number;
        logic [SLOT_W-1:0]  slot_index;
    } t_req;

    // response item
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               needs_writeback;
        logic [INODE_W-1:0] evicted_inode;
        logic               needs_load;
    } t_rsp;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_UPDATE,
        S_MARK,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic mark;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/iclfu_req_if.sv =====
// ----------------------------------------------------------------------------
// iclfu_req_if
// Request channel: valid/ready handshake carrying one lookup or mark item.
// ----------------------------------------------------------------------------
`default_nettype none

interface iclfu_req_if import iclfu_pkg::*; ();

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/iclfu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// iclfu_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface iclfu_rsp_if import iclfu_pkg::*; ();

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/iclfu_ram.sv =====
// ----------------------------------------------------------------------------
// iclfu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module iclfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/iclfu_dp.sv =====
// ----------------------------------------------------------------------------
// iclfu_dp
// Datapath: slot RAM (tag and use count), valid and dirty bits, scan
// trackers for match, first empty slot and least count, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iclfu_dp import iclfu_pkg::*; #(
    parameter int SLOTS      = 16,
    parameter int INODE_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_rsp    o_rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int TW = (INODE_BITS < INODE_W) ? INODE_BITS : INODE_W;
    localparam int IW = (SW > SLOT_W) ? SW : SLOT_W;
    localparam int RW = TW + COUNT_BITS;
    localparam logic [SW-1:0]         LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

    // captured request
    logic [TW-1:0]     r_ino;
    logic [SLOT_W-1:0] r_sidx;

    // scan pipeline
    logic [SW-1:0] r_addr;
    logic          r_cmp_vld;
    logic [SW-1:0] r_cmp_idx;

    // per-slot flags
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_dirty;

    // trackers
    logic                  r_hit_f;
    logic [SW-1:0]         r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic                  r_empty_f;
    logic [SW-1:0]         r_empty_idx;
    logic [SW-1:0]         r_min_idx;
    logic [COUNT_BITS-1:0] r_min_cnt;
    logic [TW-1:0]         r_min_tag;

    t_rsp r_rsp;

    logic [RW-1:0]         w_rd_data;
    logic [TW-1:0]         w_rd_tag;
    logic [COUNT_BITS-1:0] w_rd_cnt;
    logic                  w_cmp_v;
    logic                  w_match;
    logic                  w_take_min;
    logic [SW-1:0]         w_upd_idx;
    logic [IW-1:0]         w_upd_ext;
    logic [COUNT_BITS-1:0] w_new_cnt;
    logic                  w_evict_f;
    logic                  w_wb;
    logic [INODE_W-1:0]    w_evict;
    logic [IW-1:0]         w_sidx_ext;
    logic                  w_sidx_ok;
    logic [SW-1:0]         w_mark_addr;

    // slot storage: tag in the upper bits, use count in the lower
    iclfu_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.update),
        .i_wr_addr (w_upd_idx),
        .i_wr_data ({r_ino, w_new_cnt}),
        .i_rd_en   (i_cmd.scan),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    // compare stage
    assign w_rd_tag   = w_rd_data[RW-1:COUNT_BITS];
    assign w_rd_cnt   = w_rd_data[COUNT_BITS-1:0];
    assign w_cmp_v    = r_valid[r_cmp_idx];
    assign w_match    = r_cmp_vld && w_cmp_v && (w_rd_tag == r_ino);
    // slot 0 never competes; slot 1 seeds the minimum, strict less keeps lowest
    assign w_take_min = r_cmp_vld && (r_cmp_idx != '0)
                        && ((r_cmp_idx == SW'(1)) || (w_rd_cnt < r_min_cnt));

    // update selection
    assign w_evict_f = !r_hit_f && !r_empty_f;
    assign w_upd_idx = r_hit_f   ? r_hit_idx
                     : r_empty_f ? r_empty_idx
                     : r_min_idx;
    assign w_upd_ext = IW'(w_upd_idx);
    assign w_new_cnt = !r_hit_f              ? COUNT_BITS'(1)
                     : (r_hit_cnt == CNT_MAX) ? r_hit_cnt
                     : r_hit_cnt + 1'b1;
    assign w_wb      = w_evict_f && r_dirty[r_min_idx];
    assign w_evict   = w_evict_f ? INODE_W'(r_min_tag) : '0;

    // mark dirty addressing, out-of-range slots ignored
    assign w_sidx_ext  = IW'(r_sidx);
    assign w_sidx_ok   = ({1'b0, w_sidx_ext} < (IW + 1)'(SLOTS));
    assign w_mark_addr = w_sidx_ext[SW-1:0];

    assign o_sts.scan_last = (r_addr == LAST_SLOT);
    assign o_rsp           = r_rsp;

    // request capture and scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ino  <= i_req.inode_number[TW-1:0];
            r_sidx <= i_req.slot_index;
            r_addr <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + 1'b1;
        end
        r_cmp_idx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
        end
    end

    // trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_f   <= 1'b0;
            r_empty_f <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit_f   <= 1'b0;
            r_empty_f <= 1'b0;
        end else begin
            if (w_match && !r_hit_f) begin
                r_hit_f   <= 1'b1;
            end
            if (r_cmp_vld && !w_cmp_v && !r_empty_f) begin
                r_empty_f <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match && !r_hit_f) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_cnt <= w_rd_cnt;
        end
        if (r_cmp_vld && !w_cmp_v && !r_empty_f) begin
            r_empty_idx <= r_cmp_idx;
        end
        if (w_take_min) begin
            r_min_idx <= r_cmp_idx;
            r_min_cnt <= w_rd_cnt;
            r_min_tag <= w_rd_tag;
        end
    end

    // valid and dirty bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else begin
            if (i_cmd.update && !r_hit_f) begin
                r_valid[w_upd_idx] <= 1'b1;
                r_dirty[w_upd_idx] <= 1'b0;
            end
            if (i_cmd.mark && w_sidx_ok) begin
                r_dirty[w_mark_addr] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rsp.hit             <= r_hit_f;
            r_rsp.slot            <= w_upd_ext[SLOT_W-1:0];
            r_rsp.needs_writeback <= w_wb;
            r_rsp.evicted_inode   <= w_evict;
            r_rsp.needs_load      <= !r_hit_f;
        end else if (i_cmd.mark) begin
            r_rsp.hit             <= 1'b0;
            r_rsp.slot            <= r_sidx;
            r_rsp.needs_writeback <= 1'b0;
            r_rsp.evicted_inode   <= '0;
            r_rsp.needs_load      <= 1'b0;
        end
    end

    // a filled slot is valid afterwards
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !r_hit_f) |=> r_valid[$past(w_upd_idx)])
        else $error("filled slot not valid");

    // eviction never picks slot 0
    a_no_slot0_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && w_evict_f) |-> (w_upd_idx != '0))
        else $error("slot 0 chosen as victim");

    // a full table is never reported with an empty slot found
    a_empty_only_if_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_empty_f) |-> !r_valid[r_empty_idx])
        else $error("empty slot tracker points at valid slot");

endmodule

`default_nettype wire

// ===== hw/rtl/iclfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// iclfu_ctrl
// Controller: sequences request capture, slot scan, update and response.
// ----------------------------------------------------------------------------
`default_nettype none

module iclfu_ctrl import iclfu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_cmd == CMD_MARK_DIRTY) ? S_MARK : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_RESP;
            S_MARK:   n_state = S_RESP;
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN:   o_cmd.scan   = 1'b1;
            S_WAIT:   ;
            S_UPDATE: o_cmd.update = 1'b1;
            S_MARK:   o_cmd.mark   = 1'b1;
            S_RESP:   o_out_valid  = 1'b1;
            default:  ;
        endcase
    end

    // a result appears only right after an update or a mark
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid))
        |-> ($past(r_state) == S_UPDATE || $past(r_state) == S_MARK))
        else $error("result raised without update");

    // an accepted item never shows a result in the next cycle
    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("result too early after accept");

    // scan end leads into the last compare cycle
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan && i_sts.scan_last) |=> (!o_cmd.scan && !o_cmd.update))
        else $error("scan did not stop at last slot");

endmodule

`default_nettype wire

// ===== hw/rtl/inode_cache_lfu_replace.sv =====
// ----------------------------------------------------------------------------
// inode_cache_lfu_replace
// Fully associative inode slot cache with least-frequently-used replacement.
//
// i_req carries one item: cmd (lookup or mark slot dirty), inode_number and
// slot_index. o_rsp carries one result item per request: hit, slot,
// needs_writeback, evicted_inode and needs_load. Both use valid/ready; an
// item moves on a clock edge with valid and ready high.
// A lookup reads every slot once through a single RAM read port, passing
// through the scan, wait and update states before its result is valid, and
// the request side is ready again in the cycle after the result is taken. A
// mark dirty command passes through the mark state to the result state. One item
// is in flight at a time; the request side stays not ready while a result waits.
// Reset (synchronous, active low) empties all slots and clears all dirty
// marks; no clearing pass is needed, slot RAM contents are only read
// under a valid bit. A stalled receiver holds the result steady until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module inode_cache_lfu_replace import iclfu_pkg::*; #(
    parameter int SLOTS      = 16,
    parameter int INODE_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iclfu_req_if.sink   i_req,
    iclfu_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_rsp    w_rsp;
    logic    w_in_ready;
    logic    w_out_valid;

    iclfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_cmd    (i_req.data.cmd),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    iclfu_dp #(
        .SLOTS      (SLOTS),
        .INODE_BITS (INODE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (w_rsp)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;
    assign o_rsp.data  = w_rsp;

endmodule

`default_nettype wire

// ===== tb/inode_cache_lfu_replace_test.sv =====
// ----------------------------------------------------------------------------
// inode_cache_lfu_replace_test
// Self-checking testbench for the inode slot cache with LFU replacement.
//
// A scoreboard model keeps its own copy of the slot table (tags, valid bits,
// use counts, dirty marks) and works out the result of every accepted request
// item. Each response item is compared field by field with the oldest
// expected one. The run covers directed fills, hits, dirty marks and
// evictions, use count saturation, a long receiver hold-off, and random
// traffic under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module inode_cache_lfu_replace_test;

    import iclfu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT      = 16;
    localparam int TAG_BITS   = 16;
    // narrow use counters so that saturation is reached within a short run
    localparam int USE_BITS   = 4;
    localparam logic [USE_BITS-1:0] USE_MAX = '1;

    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 50;

    logic i_clk;
    logic i_rst_n;

    iclfu_req_if req_if ();
    iclfu_rsp_if rsp_if ();

    inode_cache_lfu_replace #(
        .SLOTS      (NSLOT),
        .INODE_BITS (TAG_BITS),
        .COUNT_BITS (USE_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // scoreboard copy of the slot table
    logic [TAG_BITS-1:0] cache_tag   [NSLOT];
    logic                cache_valid [NSLOT];
    logic [USE_BITS-1:0] use_cnt     [NSLOT];
    logic                cache_dirty [NSLOT];

    t_rsp expected_rsp [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold = 1'b0;

    logic [TAG_BITS-1:0] inode_pool [POOL_SIZE];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run length guard
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[inode_cache_lfu_replace] ERROR");
                $finish;
            end
        end
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("%0t MISMATCH: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Apply one request to the scoreboard table, return the result it causes
    function automatic t_rsp slot_access(input t_req item);
        t_rsp                rsp;
        int                  victim;
        logic [USE_BITS-1:0] least;
        bit                  found_empty;
        rsp = '0;
        if (item.cmd == CMD_MARK_DIRTY) begin
            cache_dirty[item.slot_index] = 1'b1;
            rsp.slot = item.slot_index;
            return rsp;
        end
        // hit: raise the use count, saturating
        for (int i = 0; i < NSLOT; i++) begin
            if (cache_valid[i] && cache_tag[i] == item.inode_number) begin
                if (use_cnt[i] != USE_MAX) begin
                    use_cnt[i] = use_cnt[i] + 1'b1;
                end
                rsp.hit  = 1'b1;
                rsp.slot = i[SLOT_W-1:0];
                return rsp;
            end
        end
        // miss: lowest empty slot first
        victim = 0;
        found_empty = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            if (!found_empty && !cache_valid[i]) begin
                victim = i;
                found_empty = 1'b1;
            end
        end
        // table full: least used among slots 1.., lowest index on a tie
        if (!found_empty) begin
            victim = 1;
            least  = use_cnt[1];
            for (int i = 2; i < NSLOT; i++) begin
                if (use_cnt[i] < least) begin
                    least  = use_cnt[i];
                    victim = i;
                end
            end
            rsp.needs_writeback = cache_dirty[victim];
            rsp.evicted_inode   = cache_tag[victim];
        end
        cache_tag[victim]   = item.inode_number;
        cache_valid[victim] = 1'b1;
        cache_dirty[victim] = 1'b0;
        use_cnt[victim]     = USE_BITS'(1);
        rsp.slot       = victim[SLOT_W-1:0];
        rsp.needs_load = 1'b1;
        return rsp;
    endfunction

    function automatic t_req lookup_req(input logic [TAG_BITS-1:0] inode,
                                        input logic [SLOT_W-1:0] junk);
        t_req item;
        item.cmd          = CMD_LOOKUP;
        item.inode_number = inode;
        item.slot_index   = junk;
        return item;
    endfunction

    function automatic t_req mark_req(input logic [SLOT_W-1:0] slot,
                                      input logic [TAG_BITS-1:0] junk);
        t_req item;
        item.cmd          = CMD_MARK_DIRTY;
        item.inode_number = junk;
        item.slot_index   = slot;
        return item;
    endfunction

    // Offer one request item, with random sender gaps; returns once accepted
    task automatic send_item(input t_req item);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_rsp.push_back(slot_access(item));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Response side: check accepted items, then pick next ready
    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (expected_rsp.size() == 0) begin
            report_error($sformatf("response item with none expected: %h", got));
            return;
        end
        want = expected_rsp.pop_front();
        if (got.hit !== want.hit)
            report_error($sformatf("hit %b, want %b", got.hit, want.hit));
        if (got.slot !== want.slot)
            report_error($sformatf("slot %0d, want %0d", got.slot, want.slot));
        if (got.needs_writeback !== want.needs_writeback)
            report_error($sformatf("needs_writeback %b, want %b",
                                   got.needs_writeback, want.needs_writeback));
        if (got.evicted_inode !== want.evicted_inode)
            report_error($sformatf("evicted_inode %h, want %h",
                                   got.evicted_inode, want.evicted_inode));
        if (got.needs_load !== want.needs_load)
            report_error($sformatf("needs_load %b, want %b",
                                   got.needs_load, want.needs_load));
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                check_result(rsp_if.data);
            end
            if (rx_hold) begin
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Fill from empty, hits, dirty marks on empty and valid slots, evictions
    task automatic test_fill_and_hit();
        send_item(lookup_req(16'h0000, 4'hF));   // tag 0 must still miss
        send_item(lookup_req(16'hFFFF, 4'h0));
        send_item(lookup_req(16'h0000, 4'h5));   // hit
        send_item(mark_req(4'hF, 16'hFFFF));     // mark an empty slot
        send_item(mark_req(4'h1, 16'h0000));
        send_item(lookup_req(16'hFFFF, 4'hA));   // hit on a dirty slot
        // fill the rest; slot 15 loses its early dirty mark
        for (int i = 2; i < NSLOT; i++) begin
            send_item(lookup_req(TAG_BITS'(i * 16'h1111) ^ 16'h5A5A, 4'(i)));
        end
        send_item(mark_req(4'h2, 16'hA5A5));
        send_item(lookup_req(16'h8001, 4'h3));   // dirty victim, writeback
        send_item(lookup_req(16'h7FFE, 4'hC));   // clean victim
        wait_drained();
    endtask

    // Saturate the use count of slot 1, keep slot 0 least used, then force evictions
    task automatic test_victim_choice();
        for (int n = 0; n < 20; n++) begin
            send_item(lookup_req(cache_tag[1], 4'(n)));
        end
        for (int s = 2; s < NSLOT; s++) begin
            send_item(lookup_req(cache_tag[s], 4'h0));
            send_item(lookup_req(cache_tag[s], 4'hF));
        end
        for (int n = 0; n < 6; n++) begin
            send_item(lookup_req(16'h4000 + TAG_BITS'(n), 4'(n)));
        end
        send_item(mark_req(4'h0, 16'h1234));
        send_item(lookup_req(16'h0F0F, 4'h0));
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int n = 0; n < 8; n++) begin
            send_item(lookup_req(TAG_BITS'($urandom), 4'($urandom)));
        end
        wait_drained();
    endtask

    // Random traffic over a hot inode pool under one idling mix
    task automatic test_random(input int unsigned count,
                               input int unsigned idle_pct,
                               input int unsigned stall_pct);
        int unsigned pick;
        t_req        item;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        for (int i = 0; i < POOL_SIZE; i++) begin
            inode_pool[i] = TAG_BITS'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                item = mark_req(4'($urandom), TAG_BITS'($urandom));
            end else if (pick < 75) begin
                // low pool indexes come up more often and saturate
                item = lookup_req(inode_pool[$urandom_range($urandom_range(POOL_SIZE-1))],
                                  4'($urandom));
            end else if (pick < 90) begin
                item = lookup_req(cache_tag[$urandom_range(NSLOT-1)], 4'($urandom));
            end else begin
                item = lookup_req(TAG_BITS'($urandom), 4'($urandom));
            end
            send_item(item);
        end
        wait_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            cache_tag[i]   = '0;
            cache_valid[i] = 1'b0;
            use_cnt[i]     = '0;
            cache_dirty[i] = 1'b0;
        end
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_and_hit();
        test_victim_choice();
        test_backpressure();
        test_random(500, 0, 0);
        test_random(500, 45, 0);
        test_random(500, 0, 45);
        test_random(500, 11, 11);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[inode_cache_lfu_replace] OK");
        end else begin
            $display("[inode_cache_lfu_replace] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
